>>> hw/rtl/prpb_pkg.sv
// Package for the priority region parameter blender.
// Holds shared types, command and status codes, sizes and reset values.
// No dependencies.
package prpb_pkg;

  localparam int unsigned MaxRegionsDef = 16;
  localparam logic [30:0] BaseReset     = 31'd65536;
  localparam logic [16:0] WeightOne     = 17'd65536;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_ZOOM = 2'd0,
    CFG_DAMP = 2'd1,
    CFG_LOOK = 2'd2
  } cfg_idx_t;

  // One stored region: 351 bits packed.
  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] y0;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic        [30:0] mrg;
    logic signed [31:0] pri;
    logic        [30:0] hnd;
    logic        [30:0] zoom;
    logic        [30:0] damp;
    logic        [30:0] look;
    logic signed [31:0] lock;
    logic        [3:0]  pf;
  } region_t;

  // Request to and answer from the shared divider.
  typedef struct packed {
    logic        go;
    logic [47:0] num;
    logic [30:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RM_READ,
    S_RM_WAIT,
    S_RM_MOVE,
    S_Q_READ,
    S_Q_WAIT,
    S_Q_WGT,
    S_Q_DIV,
    S_Q_SEL,
    S_Q_RD2,
    S_Q_WT2,
    S_Q_BLEND,
    S_Q_CAM,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/prpb_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module prpb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/prpb_div.sv
// Restoring divider, one quotient bit per cycle, quotient kept to its low 17 bits.
// Depends on prpb_pkg.
module prpb_div
  import prpb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [47:0] num_r, num_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] den_r;
  logic [16:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [31:0] trial;

  always_comb begin
    trial   = {rem_r[30:0], num_r[47]};
    num_nxt = {num_r[46:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      quo_nxt = {quo_r[15:0], 1'b1};
    end else begin
      rem_nxt = trial;
      quo_nxt = {quo_r[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd48;
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r   <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quo  <= quo_nxt;
        end
      end
    end
  end
endmodule

>>> hw/rtl/prpb_blend.sv
// Shared blend unit: base + round((target - base) * w / 65536), ties up.
// Two stages: registered multiply, then rounding add. Depends on prpb_pkg.
module prpb_blend
  import prpb_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] base,
  input  logic signed [32:0] target,
  input  logic        [16:0] wgt,
  output logic signed [32:0] result
);
  logic signed [33:0] diff;
  logic signed [51:0] prod_r;
  logic signed [32:0] base_r;
  logic signed [51:0] rnd;

  assign diff = 34'(target) - 34'(base);
  assign rnd  = prod_r + 52'sd32768;

  always_ff @(posedge clk) begin
    prod_r <= 52'(diff) * $signed({35'd0, wgt});
    base_r <= base;
  end

  // Arithmetic shift floors, matching the rounding of the model.
  assign result = base_r + 33'(rnd >>> 16);
endmodule

>>> hw/rtl/priority_region_param_blender.sv
// Top level of the priority region parameter blender.
// Depends on prpb_pkg, prpb_ram, prpb_div and prpb_blend.
//
// One item is a command: add, remove, clear or query. Start is taken when
// busy is low; one result appears later with done high for a single cycle,
// and the receiver cannot stall it. Add and clear hold busy high only in
// S_DONE, which sets the registered done. Remove reads and compacts the
// table, passing S_RM_READ, S_RM_WAIT and S_RM_MOVE for each stored region.
// A query reads each region and checks its weight (S_Q_READ, S_Q_WAIT,
// S_Q_WGT), plus a division on the shared divider (skipped for regions that
// miss the focus point, hard edges or deep interiors). Then, for each region
// with a weight, a selection scan over the whole table, a table read and a
// blend of up to four values on the shared two-stage blend unit; last comes
// the camera pull in S_Q_CAM.
// Table contents are kept in one RAM; only entries below the fill count are
// read, so no clearing pass is needed after reset.
module priority_region_param_blender
  import prpb_pkg::*;
#(
  parameter int unsigned MaxRegions = MaxRegionsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic        [1:0]  in_command,
  input  logic signed [31:0] in_coord_a,
  input  logic signed [31:0] in_coord_b,
  input  logic signed [31:0] in_coord_c,
  input  logic signed [31:0] in_coord_d,
  input  logic        [30:0] in_margin,
  input  logic signed [31:0] in_tag,
  input  logic        [30:0] in_zoom_value,
  input  logic        [30:0] in_damping_value,
  input  logic        [30:0] in_lookahead_value,
  input  logic signed [31:0] in_lock_value,
  input  logic        [3:0]  in_present_flags,
  output logic               done,
  output logic        [1:0]  out_status,
  output logic        [30:0] out_new_handle,
  output logic        [30:0] out_out_zoom,
  output logic        [30:0] out_out_damping,
  output logic        [30:0] out_out_lookahead,
  output logic signed [31:0] out_out_lock_y,
  output logic               out_lock_valid,
  output logic        [16:0] out_lock_weight,
  output logic signed [31:0] out_new_camera_y,
  output logic               out_camera_moved,
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_index,
  input  logic        [30:0] cfg_data
);
  localparam int unsigned AW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int unsigned CW = $clog2(MaxRegions + 1);
  localparam logic [CW-1:0] CntMax = CW'(MaxRegions);

  state_t state_r, state_nxt;

  logic [30:0] base_zoom_r, base_damp_r, base_look_r;
  logic [CW-1:0] count_r;
  logic [30:0]   handle_ctr_r;

  // Latched item fields.
  logic signed [31:0] fx_r, fy_r, cam_r, tag_r;

  // Scan indexes: i reads, j writes (remove).
  logic [CW-1:0] i_r, j_r;

  // Per-entry weights, kept as registers each read at its own index.
  logic [16:0] wt_r [MaxRegions];
  logic signed [31:0] pri_r [MaxRegions];
  logic [MaxRegions-1:0] used_r;

  // Selection of the next entry to blend.
  logic [CW-1:0]      sel_i_r;
  logic               sel_ok_r;
  logic signed [31:0] sel_pri_r;

  // Blend accumulators.
  logic [30:0]        zoom_r, damp_r, look_r;
  logic signed [31:0] lock_r;
  logic               lock_ok_r;
  logic [16:0]        lock_w_r;
  logic [1:0]         bph_r;
  logic [2:0]         bstep_r;

  // RAM.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  region_t       ram_wdata, ram_rdata, ent_r;

  prpb_ram #(.Width($bits(region_t)), .Depth(MaxRegions)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  div_req_t dreq;
  div_rsp_t drsp;
  prpb_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic signed [32:0] b_base, b_tgt, b_res;
  logic        [16:0] b_w;
  prpb_blend u_blend (.clk(clk), .base(b_base), .target(b_tgt), .wgt(b_w), .result(b_res));

  wire accept = start && (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);

  // Weight geometry of the entry just read (ent_r).
  logic in_box;
  logic signed [32:0] dx0, dx1, dy0, dy1, dmin01, dmin23, dmin;
  always_comb begin
    in_box = !(fx_r < ent_r.x0 || fx_r > ent_r.x1 || fy_r < ent_r.y0 || fy_r > ent_r.y1);
    dx0 = 33'(fx_r) - 33'(ent_r.x0);
    dx1 = 33'(ent_r.x1) - 33'(fx_r);
    dy0 = 33'(fy_r) - 33'(ent_r.y0);
    dy1 = 33'(ent_r.y1) - 33'(fy_r);
    dmin01 = (dx1 < dx0) ? dx1 : dx0;
    dmin23 = (dy1 < dy0) ? dy1 : dy0;
    dmin = (dmin23 < dmin01) ? dmin23 : dmin01;
  end
  wire deep = (dmin[31:0] >= {1'b0, ent_r.mrg});

  // Selection candidate: an unused entry with a weight and the lowest priority; the first one found wins a tie.
  logic [AW-1:0] scan_a;
  assign scan_a = i_r[AW-1:0];
  logic cand;
  always_comb begin
    cand = 1'b0;
    if (i_r < count_r && used_r[scan_a] == 1'b0 && wt_r[scan_a] != 17'd0) begin
      cand = !sel_ok_r || (pri_r[scan_a] < sel_pri_r);
    end
  end

  // Blend unit operand selection by step.
  logic [16:0] cur_w;
  assign cur_w = wt_r[sel_i_r[AW-1:0]];
  always_comb begin
    b_w = cur_w;
    unique case (bstep_r)
      3'd0: begin b_base = {2'b0, zoom_r}; b_tgt = {2'b0, ent_r.zoom}; end
      3'd1: begin b_base = {2'b0, damp_r}; b_tgt = {2'b0, ent_r.damp}; end
      3'd2: begin b_base = {2'b0, look_r}; b_tgt = {2'b0, ent_r.look}; end
      3'd3: begin
        b_base = lock_ok_r ? 33'(lock_r) : 33'(ent_r.lock);
        b_tgt  = 33'(ent_r.lock);
      end
      default: begin b_base = 33'(cam_r); b_tgt = 33'(lock_r); b_w = lock_w_r; end
    endcase
  end

  wire add_bad = (in_coord_a > in_coord_c) || (in_coord_b > in_coord_d) ||
                 (in_present_flags[0] && in_zoom_value == 31'd0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) begin
        unique case (cmd_t'(in_command))
          CMD_ADD, CMD_CLEAR: state_nxt = S_DONE;
          CMD_REMOVE:         state_nxt = S_RM_READ;
          CMD_QUERY:          state_nxt = S_Q_READ;
          default:            state_nxt = S_DONE;
        endcase
      end
      S_RM_READ: state_nxt = (i_r < count_r) ? S_RM_WAIT : S_DONE;
      S_RM_WAIT: state_nxt = S_RM_MOVE;
      S_RM_MOVE: state_nxt = S_RM_READ;
      S_Q_READ:  state_nxt = (i_r < count_r) ? S_Q_WAIT : S_Q_SEL;
      S_Q_WAIT:  state_nxt = S_Q_WGT;
      S_Q_WGT:   state_nxt = (!in_box || ent_r.mrg == 31'd0 || deep) ? S_Q_READ : S_Q_DIV;
      S_Q_DIV:   state_nxt = drsp.done ? S_Q_READ : S_Q_DIV;
      S_Q_SEL:   if (i_r >= count_r) state_nxt = sel_ok_r ? S_Q_RD2 : S_Q_CAM;
      S_Q_RD2:   state_nxt = S_Q_WT2;
      S_Q_WT2:   state_nxt = S_Q_BLEND;
      S_Q_BLEND: if (bstep_r == 3'd3 && (bph_r == 2'd1 || !ent_r.pf[3])) state_nxt = S_Q_SEL;
      S_Q_CAM:   if (bph_r == 2'd1 || !lock_ok_r) state_nxt = S_DONE;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // RAM port and divider request.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = ent_r;
    ram_raddr = i_r[AW-1:0];
    dreq.go   = 1'b0;
    dreq.num  = {dmin[31:0], 16'd0};
    dreq.den  = ent_r.mrg;
    unique case (state_r)
      S_IDLE: begin
        ram_wdata = '{x0: in_coord_a, y0: in_coord_b, x1: in_coord_c, y1: in_coord_d,
                      mrg: in_margin, pri: in_tag, hnd: handle_ctr_r,
                      zoom: in_zoom_value, damp: in_damping_value,
                      look: in_lookahead_value, lock: in_lock_value,
                      pf: in_present_flags};
        ram_we = accept && cmd_t'(in_command) == CMD_ADD && !add_bad && count_r < CntMax;
      end
      S_RM_MOVE: begin
        ram_waddr = j_r[AW-1:0];
        ram_we    = ({1'b0, ent_r.hnd} != tag_r) && (j_r != i_r - CW'(1));
      end
      S_Q_WGT: dreq.go = in_box && ent_r.mrg != 31'd0 && !deep;
      S_Q_RD2: ram_raddr = sel_i_r[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      handle_ctr_r <= '0;
      base_zoom_r  <= BaseReset;
      base_damp_r  <= BaseReset;
      base_look_r  <= BaseReset;
      done         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done    <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ZOOM: base_zoom_r <= cfg_data;
          CFG_DAMP: base_damp_r <= cfg_data;
          CFG_LOOK: base_look_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (accept) begin
          fx_r  <= in_coord_a;
          fy_r  <= in_coord_b;
          cam_r <= in_coord_c;
          tag_r <= in_tag;
          i_r   <= '0;
          j_r   <= '0;
          out_status        <= ST_OK;
          out_new_handle    <= '0;
          out_out_zoom      <= '0;
          out_out_damping   <= '0;
          out_out_lookahead <= '0;
          out_out_lock_y    <= '0;
          out_lock_valid    <= 1'b0;
          out_lock_weight   <= '0;
          out_new_camera_y  <= '0;
          out_camera_moved  <= 1'b0;
          zoom_r    <= base_zoom_r;
          damp_r    <= base_damp_r;
          look_r    <= base_look_r;
          lock_r    <= '0;
          lock_ok_r <= 1'b0;
          lock_w_r  <= '0;
          used_r    <= '0;
          sel_ok_r  <= 1'b0;
          bph_r     <= '0;
          bstep_r   <= '0;
          unique case (cmd_t'(in_command))
            CMD_ADD: begin
              if (add_bad) out_status <= ST_INVALID;
              else if (count_r >= CntMax) out_status <= ST_FULL;
              else begin
                out_new_handle <= handle_ctr_r;
                handle_ctr_r   <= handle_ctr_r + 31'd1;
                count_r        <= count_r + CW'(1);
              end
            end
            CMD_CLEAR: count_r <= '0;
            default: ;
          endcase
        end
        S_RM_READ: if (i_r >= count_r) count_r <= j_r;
        S_RM_WAIT: begin
          ent_r <= ram_rdata;
          i_r   <= i_r + CW'(1);
        end
        S_RM_MOVE: if ({1'b0, ent_r.hnd} != tag_r) j_r <= j_r + CW'(1);
        S_Q_READ: if (i_r >= count_r) i_r <= '0;
        S_Q_WAIT: ent_r <= ram_rdata;
        S_Q_WGT: begin
          pri_r[scan_a] <= ent_r.pri;
          if (!in_box) wt_r[scan_a] <= '0;
          else if (ent_r.mrg == 31'd0 || deep) wt_r[scan_a] <= WeightOne;
          if (!in_box || ent_r.mrg == 31'd0 || deep) i_r <= i_r + CW'(1);
        end
        S_Q_DIV: if (drsp.done) begin
          wt_r[scan_a] <= drsp.quo;
          i_r <= i_r + CW'(1);
        end
        S_Q_SEL: begin
          if (cand) begin
            sel_ok_r  <= 1'b1;
            sel_i_r   <= i_r;
            sel_pri_r <= pri_r[scan_a];
          end
          if (i_r < count_r) i_r <= i_r + CW'(1);
          else if (sel_ok_r) used_r[sel_i_r[AW-1:0]] <= 1'b1;
        end
        S_Q_WT2: begin
          ent_r   <= ram_rdata;
          bstep_r <= '0;
          bph_r   <= '0;
        end
        S_Q_BLEND: begin
          if (bph_r == 2'd0) begin
            if (ent_r.pf[bstep_r[1:0]]) bph_r <= 2'd1;
            else if (bstep_r != 3'd3) bstep_r <= bstep_r + 3'd1;
            else begin
              sel_ok_r <= 1'b0;
              i_r      <= '0;
            end
          end else begin
            bph_r <= 2'd0;
            unique case (bstep_r)
              3'd0: zoom_r <= b_res[30:0];
              3'd1: damp_r <= b_res[30:0];
              3'd2: look_r <= b_res[30:0];
              default: begin
                lock_r    <= b_res[31:0];
                lock_ok_r <= 1'b1;
                if (cur_w > lock_w_r) lock_w_r <= cur_w;
              end
            endcase
            if (bstep_r != 3'd3) bstep_r <= bstep_r + 3'd1;
            else begin
              sel_ok_r <= 1'b0;
              i_r      <= '0;
            end
          end
        end
        S_Q_CAM: begin
          bstep_r <= 3'd4;
          if (!lock_ok_r || bph_r == 2'd1) begin
            out_out_zoom      <= zoom_r;
            out_out_damping   <= damp_r;
            out_out_lookahead <= look_r;
            out_out_lock_y    <= lock_r;
            out_lock_valid    <= lock_ok_r;
            out_lock_weight   <= lock_w_r;
            out_camera_moved  <= lock_ok_r;
            out_new_camera_y  <= lock_ok_r ? b_res[31:0] : cam_r;
          end else if (bstep_r == 3'd4) bph_r <= 2'd1;
        end
        S_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

>>> hw/rtl/prpb_checker.sv
// Port-level checker for the priority region parameter blender.
// Depends on prpb_pkg; bound to the top level below.
module prpb_checker
  import prpb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  out_status,
  input logic [16:0] out_lock_weight,
  input logic        out_lock_valid,
  input logic        out_camera_moved
);
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("item not taken");
  a_done_drop: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("result held");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> out_status != 2'd3) else $error("bad status");
  a_weight: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> out_lock_weight <= 17'd65536) else $error("weight above one");
  a_moved: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> out_camera_moved == out_lock_valid) else $error("move without lock");
endmodule

bind priority_region_param_blender prpb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
  .out_status(out_status), .out_lock_weight(out_lock_weight),
  .out_lock_valid(out_lock_valid), .out_camera_moved(out_camera_moved)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for priority_region_param_blender.
// Depends on prpb_pkg and the block itself; it carries its own predictor of the region
// table and compares every result item against it.
module tb_top;
  import prpb_pkg::*;

  // Longest stretch of cycles in which neither an item nor a result may be accepted.
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned ItemsPerPhase = 440;
  localparam int signed   World = 1 << 22;

  typedef struct {
    cmd_t               cmd;
    logic signed [31:0] a, b, c, d;
    logic        [30:0] mrg;
    logic signed [31:0] tag;
    logic        [30:0] zv, dv, lv;
    logic signed [31:0] lk;
    logic        [3:0]  pf;
  } cmd_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [30:0] handle;
    logic [30:0] zoom, damp, look;
    logic [31:0] lock_y;
    logic        lock_valid;
    logic [16:0] lock_w;
    logic [31:0] cam_y;
    logic        moved;
  } answer_t;

  // One stored region, as the predictor keeps it.
  typedef struct {
    longint      x0, y0, x1, y1, mrg, pri;
    logic [30:0] hnd;
    longint      zoom, damp, look, lock;
    logic [3:0]  pf;
  } zone_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic        [1:0]  in_command = '0;
  logic signed [31:0] in_coord_a = '0;
  logic signed [31:0] in_coord_b = '0;
  logic signed [31:0] in_coord_c = '0;
  logic signed [31:0] in_coord_d = '0;
  logic        [30:0] in_margin = '0;
  logic signed [31:0] in_tag = '0;
  logic        [30:0] in_zoom_value = '0;
  logic        [30:0] in_damping_value = '0;
  logic        [30:0] in_lookahead_value = '0;
  logic signed [31:0] in_lock_value = '0;
  logic        [3:0]  in_present_flags = '0;
  logic done;
  logic        [1:0]  out_status;
  logic        [30:0] out_new_handle;
  logic        [30:0] out_out_zoom;
  logic        [30:0] out_out_damping;
  logic        [30:0] out_out_lookahead;
  logic signed [31:0] out_out_lock_y;
  logic               out_lock_valid;
  logic        [16:0] out_lock_weight;
  logic signed [31:0] out_new_camera_y;
  logic               out_camera_moved;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  always #2 clk = ~clk;

  priority_region_param_blender dut (.*);

  // Predictor state: the region table, its fill count, the handle counter and the baselines.
  zone_t       zones [16];
  int          zone_count = 0;
  logic [30:0] next_handle = '0;
  logic [30:0] base_zoom = BaseReset;
  logic [30:0] base_damp = BaseReset;
  logic [30:0] base_look = BaseReset;

  cmd_item_t pending_cmds[$];
  answer_t   expected_answers[$];
  cmd_item_t cur_cmd;
  bit        cmd_in_flight = 1'b0;
  bit        idle_enable = 1'b1;
  int        gap_left = 0;
  int        errors = 0;
  int        stalled_cycles = 0;
  int        gen_adds = 0;
  int        n_added = 0, n_full = 0, n_invalid = 0, n_queries = 0, n_locked = 0;
  int        n_removes = 0, n_clears = 0;

  // Appends an item to the sender's queue.
  function automatic void enqueue_cmd(cmd_item_t it);
    pending_cmds.insert(pending_cmds.size(), it);
  endfunction

  // Appends a predicted result to the monitor's queue.
  function automatic void enqueue_answer(answer_t r);
    expected_answers.insert(expected_answers.size(), r);
  endfunction

  // Blend toward a target by a Q1.16 weight; ties round toward plus infinity.
  function automatic longint blend_toward(longint base, longint target, longint w);
    longint t;
    t = (target - base) * w + 32768;
    return base + (t >>> 16);
  endfunction

  // Weight of one stored region for a focus point, Q1.16.
  function automatic longint zone_weight(int i, longint fx, longint fy);
    longint reach;
    if (fx < zones[i].x0 || fx > zones[i].x1 || fy < zones[i].y0 || fy > zones[i].y1)
      return 0;
    if (zones[i].mrg == 0) return 65536;
    reach = fx - zones[i].x0;
    if (zones[i].x1 - fx < reach) reach = zones[i].x1 - fx;
    if (fy - zones[i].y0 < reach) reach = fy - zones[i].y0;
    if (zones[i].y1 - fy < reach) reach = zones[i].y1 - fy;
    if (reach >= zones[i].mrg) return 65536;
    return (reach << 16) / zones[i].mrg;
  endfunction

  // Works out the result of one accepted item and advances the predicted state.
  function automatic answer_t resolve_command(cmd_item_t it);
    answer_t r;
    int      ord[16];
    longint  wts[16];
    int      n, j, keep;
    longint  w, zoom, damp, look, lock, lock_w, cam;
    bit      lock_ok;
    r = '{default: '0};
    case (it.cmd)
      CMD_ADD: begin
        if (it.a > it.c || it.b > it.d || (it.pf[0] && it.zv == 0)) begin
          r.status = ST_INVALID;
          n_invalid++;
        end else if (zone_count >= 16) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          zones[zone_count] = '{x0: it.a, y0: it.b, x1: it.c, y1: it.d,
                                mrg: longint'(it.mrg), pri: it.tag, hnd: next_handle,
                                zoom: longint'(it.zv), damp: longint'(it.dv),
                                look: longint'(it.lv), lock: it.lk, pf: it.pf};
          zone_count++;
          r.status = ST_OK;
          r.handle = next_handle;
          next_handle = next_handle + 31'd1;
          n_added++;
        end
      end
      CMD_REMOVE: begin
        // A negative tag can never equal a 31-bit handle.
        keep = 0;
        for (int i = 0; i < zone_count; i++) begin
          if (it.tag < 0 || {1'b0, zones[i].hnd} != it.tag) begin
            zones[keep] = zones[i];
            keep++;
          end
        end
        zone_count = keep;
        n_removes++;
      end
      CMD_CLEAR: begin
        zone_count = 0;
        n_clears++;
      end
      default: begin
        n = 0;
        for (int i = 0; i < zone_count; i++) begin
          w = zone_weight(i, it.a, it.b);
          if (w > 0) begin
            // Stable insertion: equal priorities keep the order in which they were added.
            j = n;
            while (j > 0 && zones[ord[j - 1]].pri > zones[i].pri) begin
              ord[j] = ord[j - 1];
              wts[j] = wts[j - 1];
              j--;
            end
            ord[j] = i;
            wts[j] = w;
            n++;
          end
        end
        zoom = base_zoom;
        damp = base_damp;
        look = base_look;
        lock = 0;
        lock_w = 0;
        lock_ok = 1'b0;
        cam = it.c;
        for (int k = 0; k < n; k++) begin
          if (zones[ord[k]].pf[0]) zoom = blend_toward(zoom, zones[ord[k]].zoom, wts[k]);
          if (zones[ord[k]].pf[1]) damp = blend_toward(damp, zones[ord[k]].damp, wts[k]);
          if (zones[ord[k]].pf[2]) look = blend_toward(look, zones[ord[k]].look, wts[k]);
          if (zones[ord[k]].pf[3]) begin
            // The first lock starts from its own value; later ones blend over it.
            lock = blend_toward(lock_ok ? lock : zones[ord[k]].lock, zones[ord[k]].lock, wts[k]);
            lock_ok = 1'b1;
            if (wts[k] > lock_w) lock_w = wts[k];
          end
        end
        if (lock_ok && lock_w > 0) begin
          cam = blend_toward(cam, lock, lock_w);
          r.moved = 1'b1;
          n_locked++;
        end
        r.status = ST_OK;
        r.zoom = zoom[30:0];
        r.damp = damp[30:0];
        r.look = look[30:0];
        r.lock_y = lock_ok ? lock[31:0] : '0;
        r.lock_valid = lock_ok;
        r.lock_w = lock_w[16:0];
        r.cam_y = cam[31:0];
        n_queries++;
      end
    endcase
    return r;
  endfunction

  function automatic cmd_item_t make_item(cmd_t cmd, int a, int b, int c, int d,
                                          logic [30:0] mrg, int tag, logic [30:0] zv,
                                          logic [30:0] dv, logic [30:0] lv, int lk,
                                          logic [3:0] pf);
    cmd_item_t it;
    it = '{cmd: cmd, a: a, b: b, c: c, d: d, mrg: mrg, tag: tag, zv: zv, dv: dv,
           lv: lv, lk: lk, pf: pf};
    return it;
  endfunction

  // Random item: mostly well-formed regions and queries in a shared area, so that
  // queries land in overlapping regions; the rest is removes, clears and raw noise.
  function automatic cmd_item_t random_item();
    cmd_item_t   it;
    int          pick, x0, y0, wd, ht;
    logic [30:0] zv;
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      it = make_item(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom_range(0, 15));
    end else if (pick < 45) begin
      x0 = $urandom_range(0, 2 * World) - World;
      y0 = $urandom_range(0, 2 * World) - World;
      wd = $urandom_range(0, World);
      ht = $urandom_range(0, World);
      zv = ($urandom_range(0, 1) != 0) ? 31'($urandom_range(1, 4 << 16)) : 31'($urandom);
      it = make_item(CMD_ADD, x0, y0, x0 + wd, y0 + ht, 31'd0,
                     ($urandom_range(0, 4) != 0) ? $urandom_range(0, 6) - 3 : $urandom,
                     zv, $urandom_range(0, 4 << 16), $urandom, $urandom,
                     $urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0, 1, 2: it.mrg = 31'd0;
        3:       it.mrg = 31'($urandom_range(1, 255));
        4:       it.mrg = 31'($urandom);
        default: it.mrg = 31'($urandom_range(1, World / 2));
      endcase
      // A few broken regions: flipped corners or a present zero zoom.
      case ($urandom_range(0, 31))
        0: it.c = it.a - $urandom_range(1, 1000);
        1: it.d = it.b - $urandom_range(1, 1000);
        2: begin
          it.zv = '0;
          it.pf[0] = 1'b1;
        end
        default: gen_adds++;
      endcase
    end else if (pick < 55) begin
      it = make_item(CMD_REMOVE, $urandom, $urandom, $urandom, $urandom, $urandom,
                     ($urandom_range(0, 9) != 0) ? $urandom_range(0, gen_adds) : $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 15));
    end else if (pick < 57) begin
      it = make_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 15));
    end else begin
      it = make_item(CMD_QUERY, $urandom_range(0, 3 * World) - World,
                     $urandom_range(0, 3 * World) - World, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 15));
    end
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Driver: an item is accepted when start is high and busy is low. The prediction is
  // made at that edge, and the next item is presented after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        enqueue_answer(resolve_command(cur_cmd));
        cmd_in_flight = 1'b0;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          cmd_in_flight = 1'b1;
          in_command <= cur_cmd.cmd;
          in_coord_a <= cur_cmd.a;
          in_coord_b <= cur_cmd.b;
          in_coord_c <= cur_cmd.c;
          in_coord_d <= cur_cmd.d;
          in_margin <= cur_cmd.mrg;
          in_tag <= cur_cmd.tag;
          in_zoom_value <= cur_cmd.zv;
          in_damping_value <= cur_cmd.dv;
          in_lookahead_value <= cur_cmd.lv;
          in_lock_value <= cur_cmd.lk;
          in_present_flags <= cur_cmd.pf;
          start <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: a result is checked on the ports in the one cycle in which done is high.
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && done) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: result with no item waiting, status %h", $time, out_status);
        errors++;
      end else begin
        e = expected_answers.pop_front();
        check_field("status", e.status, out_status);
        check_field("new_handle", e.handle, out_new_handle);
        check_field("zoom", e.zoom, out_out_zoom);
        check_field("damping", e.damp, out_out_damping);
        check_field("lookahead", e.look, out_out_lookahead);
        check_field("lock_y", e.lock_y, $unsigned(out_out_lock_y));
        check_field("lock_valid", e.lock_valid, out_lock_valid);
        check_field("lock_weight", e.lock_w, out_lock_weight);
        check_field("new_camera_y", e.cam_y, $unsigned(out_new_camera_y));
        check_field("camera_moved", e.moved, out_camera_moved);
      end
    end
  end

  // Watchdog on cycles in which nothing at all is accepted.
  always @(posedge clk) begin
    if ((start && !busy) || done) stalled_cycles <= 0;
    else stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || cmd_in_flight || start || busy ||
           expected_answers.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_baseline(cfg_idx_t idx, logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ZOOM: base_zoom = val;
      CFG_DAMP: base_damp = val;
      default:  base_look = val;
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run on the reset baselines.
    enqueue_cmd(make_item(CMD_QUERY, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0));
    // A region covering the whole plane with the largest margin and every value present.
    enqueue_cmd(make_item(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                          32'h7fff_ffff, 31'h7fff_ffff, 0, 31'h7fff_ffff,
                          31'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 4'hf));
    enqueue_cmd(make_item(CMD_QUERY, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0, 0));
    // A point region with a hard edge, lowest priority and the most negative lock.
    enqueue_cmd(make_item(CMD_ADD, 5 << 16, 7 << 16, 5 << 16, 7 << 16, 0,
                          32'h8000_0000, 1, 0, 0, 32'h8000_0000, 4'h8));
    enqueue_cmd(make_item(CMD_QUERY, 5 << 16, 7 << 16, 32'h8000_0000, 0, 0, 0,
                          0, 0, 0, 0, 0));
    // Broken regions: flipped x, flipped y, and a zoom flagged present but zero.
    enqueue_cmd(make_item(CMD_ADD, 10, 0, 9, 5, 0, 0, 1, 0, 0, 0, 4'h0));
    enqueue_cmd(make_item(CMD_ADD, 0, 10, 5, 9, 0, 0, 1, 0, 0, 0, 4'h0));
    enqueue_cmd(make_item(CMD_ADD, 0, 0, 5, 5, 0, 0, 0, 0, 0, 0, 4'h1));
    enqueue_cmd(make_item(CMD_ADD, 0, 0, 9 << 16, 9 << 16, 3 << 16,
                          32'h7fff_ffff, 2 << 16, 0, 0, 3 << 16, 4'hf));
    enqueue_cmd(make_item(CMD_QUERY, 1 << 16, 5 << 16, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    enqueue_cmd(make_item(CMD_REMOVE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    enqueue_cmd(make_item(CMD_REMOVE, 0, 0, 0, 0, 0, -1, 0, 0, 0, 0, 0));
    enqueue_cmd(make_item(CMD_REMOVE, 0, 0, 0, 0, 0, 1000, 0, 0, 0, 0, 0));
    // Fill the table, then overflow it, then try a broken region while it is full.
    for (int i = 0; i < 15; i++)
      enqueue_cmd(make_item(CMD_ADD, -i, -i, i, i, i, i % 2, 1, 0, 0, i, 4'h9));
    enqueue_cmd(make_item(CMD_ADD, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 4'h0));
    enqueue_cmd(make_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    enqueue_cmd(make_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    enqueue_cmd(make_item(CMD_QUERY, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    gen_adds = 20;
    wait_idle();

    // Random phases, each behind a new set of baselines written while the block is idle.
    for (int ph = 1; ph <= 4; ph++) begin
      case (ph)
        1: begin
          write_baseline(CFG_ZOOM, 31'd1);
          write_baseline(CFG_DAMP, 31'd0);
          write_baseline(CFG_LOOK, 31'h7fff_ffff);
        end
        2: begin
          write_baseline(CFG_ZOOM, 31'h7fff_ffff);
          write_baseline(CFG_DAMP, 31'h7fff_ffff);
          write_baseline(CFG_LOOK, 31'd0);
        end
        default: begin
          write_baseline(CFG_ZOOM, 31'($urandom_range(1, 8 << 16)));
          write_baseline(CFG_DAMP, 31'($urandom));
          write_baseline(CFG_LOOK, 31'($urandom_range(0, 8 << 16)));
        end
      endcase
      @(posedge clk);
      cfg_we <= 1'b0;
      // The third phase runs back to back, with no idle cycles from the sender.
      idle_enable = (ph != 3);
      for (int i = 0; i < ItemsPerPhase; i++) enqueue_cmd(random_item());
      wait_idle();
    end

    repeat (40) @(posedge clk);
    $display("Covered %0d adds, %0d rejected as full, %0d rejected as invalid, %0d removes,",
             n_added, n_full, n_invalid, n_removes);
    $display("%0d clears and %0d queries (%0d moved the camera) over five baseline settings.",
             n_clears, n_queries, n_locked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
